>>> src/p1_triangle_element_matrix_top_macros.svh
// Assertion macros shared by the triangle element matrix RTL.
// Each use expands to one labelled concurrent assertion on clk, off during reset.
`ifndef P1_TRIANGLE_ELEMENT_MATRIX_TOP_MACROS_SVH
`define P1_TRIANGLE_ELEMENT_MATRIX_TOP_MACROS_SVH

// Same-cycle implication.
`define P1TEM_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define P1TEM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/p1tem_pkg.sv
// ----------------------------------------------------------------------------
// p1tem_pkg
// Widths, lane map, sideband types and helpers for the triangle element matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package p1tem_pkg;

  localparam int CW        = 32;            // coordinate / boundary value
  localparam int BW        = CW + 1;        // edge differences
  localparam int PXW       = CW + BW;       // x * beta
  localparam int PPW       = 2 * BW;        // beta * beta, gamma * gamma
  localparam int SW        = PPW + 1;       // doubled area, numerators
  localparam int NUM_SHIFT = 15;
  localparam int NSW       = SW + NUM_SHIFT;
  localparam int KW        = 48;            // Q32.16 result
  localparam int QW        = KW + 1;        // quotient bits kept
  localparam int NL        = 6;             // unique stiffness entries
  localparam int NP        = 6;             // load products
  localparam int KSPLIT    = KW / 2;
  localparam int PW        = KSPLIT + CW;
  localparam int PSW       = KW + CW;
  localparam int FRAC      = 16;
  localparam int MW        = PSW - FRAC;
  localparam int FW        = MW + 2;

  // Stiffness lanes
  localparam int L00 = 0;
  localparam int L11 = 1;
  localparam int L22 = 2;
  localparam int L01 = 3;
  localparam int L02 = 4;
  localparam int L12 = 5;
  localparam int LANE_A [NL] = '{0, 1, 2, 0, 0, 1};
  localparam int LANE_B [NL] = '{0, 1, 2, 1, 2, 2};

  // Load products: entry K(j,i) times g(i), in order (1,0) (2,0) (0,1) (2,1) (0,2) (1,2)
  localparam int P10 = 0;
  localparam int P20 = 1;
  localparam int P01 = 2;
  localparam int P21 = 3;
  localparam int P02 = 4;
  localparam int P12 = 5;
  localparam int PROD_K [NP] = '{L01, L02, L01, L12, L02, L12};
  localparam int PROD_G [NP] = '{0, 0, 1, 1, 2, 2};

  localparam logic signed [KW-1:0] K_MAX = {1'b0, {(KW-1){1'b1}}};
  localparam logic signed [KW-1:0] K_MIN = {1'b1, {(KW-1){1'b0}}};
  localparam logic signed [KW-1:0] K_ONE = KW'(65536);
  localparam logic [QW-1:0]        Q_POS_LIM = QW'({(KW-1){1'b1}});
  localparam logic [QW-1:0]        Q_NEG_LIM = {2'b01, {(KW-1){1'b0}}};

  typedef struct packed {
    logic [2:0]           mask;
    logic [2:0][CW-1:0]   g;
    logic [2:0][CW-1:0]   gmag;
    logic [2:0]           gneg;
  } bc_t;

  typedef struct packed {
    bc_t           bc;
    logic          degen;
    logic [NL-1:0] neg;
    logic [NL-1:0] ovf;
  } div_side_t;

  function automatic logic signed [KW-1:0] sat_k(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] hi;
    logic signed [FW-1:0] lo;
    hi = FW'(K_MAX);
    lo = FW'(K_MIN);
    if (v > hi) return K_MAX;
    if (v < lo) return K_MIN;
    return v[KW-1:0];
  endfunction

  // Two boundary subtractions in vertex order, each saturating.
  function automatic logic signed [KW-1:0] load_calc(input logic signed [MW-1:0] ma,
                                                     input logic use_a,
                                                     input logic signed [MW-1:0] mb,
                                                     input logic use_b);
    logic signed [FW-1:0] sa;
    logic signed [FW-1:0] sb;
    logic signed [KW-1:0] fa;
    sa = use_a ? FW'(ma) : '0;
    sb = use_b ? FW'(mb) : '0;
    fa = sat_k(FW'(0) - sa);
    return sat_k(FW'(fa) - sb);
  endfunction

endpackage

`default_nettype wire

>>> src/p1tem_div.sv
// ----------------------------------------------------------------------------
// p1tem_div
// Six-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module p1tem_div
  import p1tem_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  div_side_t               in_side,
  input  logic [SW-1:0]           in_den,
  input  logic [NL-1:0][NSW-1:0]  in_num,
  output logic                    out_valid,
  output div_side_t               out_side,
  output logic [NL-1:0][QW-1:0]   out_quo
);

  logic          v_r    [QW];
  div_side_t     side_r [QW];
  logic [SW-1:0] den_r  [QW];
  logic [SW-1:0] rem_r  [QW][NL];
  logic [QW-1:0] bits_r [QW][NL];
  logic [QW-1:0] quo_r  [QW][NL];

  logic          v_src    [QW];
  div_side_t     side_src [QW];
  logic [SW-1:0] den_src  [QW];
  logic [SW-1:0] rem_src  [QW][NL];
  logic [QW-1:0] bits_src [QW][NL];
  logic [QW-1:0] quo_src  [QW][NL];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign v_src[s]    = in_valid;
      assign side_src[s] = in_side;
      assign den_src[s]  = in_den;
      for (genvar l = 0; l < NL; l++) begin : g_lane_in
        // high numerator bits form the opening remainder
        assign rem_src[s][l]  = SW'(in_num[l][NSW-1:QW]);
        assign bits_src[s][l] = in_num[l][QW-1:0];
        assign quo_src[s][l]  = '0;
      end
    end else begin : g_body
      assign v_src[s]    = v_r[s-1];
      assign side_src[s] = side_r[s-1];
      assign den_src[s]  = den_r[s-1];
      for (genvar l = 0; l < NL; l++) begin : g_lane_link
        assign rem_src[s][l]  = rem_r[s-1][l];
        assign bits_src[s][l] = bits_r[s-1][l];
        assign quo_src[s][l]  = quo_r[s-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_src[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_src[s];
        den_r[s]  <= den_src[s];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [SW:0]   trial;
      logic [SW:0]   diff;
      logic          take;

      assign trial = {rem_src[s][l], bits_src[s][l][QW-1]};
      assign diff  = trial - {1'b0, den_src[s]};
      assign take  = trial >= {1'b0, den_src[s]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][l]  <= take ? diff[SW-1:0] : trial[SW-1:0];
          bits_r[s][l] <= {bits_src[s][l][QW-2:0], 1'b0};
          quo_r[s][l]  <= {quo_src[s][l][QW-2:0], take};
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_side  = side_r[QW-1];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_quo[l] = quo_r[QW-1][l];
  end

endmodule

`default_nettype wire

>>> src/p1_triangle_element_matrix_top.sv
// 59 register stages lie between the in_* ports and out_*.
// Throughput: one triangle per cycle unless stalled; 49 divider stages set the depth.
// A stalled output freezes the pipe only once its last stage holds a word.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// p1_triangle_element_matrix_top
// Linear triangle Laplace stiffness entries and loads with Dirichlet rows applied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "p1_triangle_element_matrix_top_macros.svh"

module p1_triangle_element_matrix_top
  import p1tem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_x0,
  input  logic signed [CW-1:0] in_y0,
  input  logic signed [CW-1:0] in_x1,
  input  logic signed [CW-1:0] in_y1,
  input  logic signed [CW-1:0] in_x2,
  input  logic signed [CW-1:0] in_y2,
  input  logic [2:0]           in_boundary_mask,
  input  logic signed [CW-1:0] in_bc_value0,
  input  logic signed [CW-1:0] in_bc_value1,
  input  logic signed [CW-1:0] in_bc_value2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [KW-1:0] out_k00,
  output logic signed [KW-1:0] out_k11,
  output logic signed [KW-1:0] out_k22,
  output logic signed [KW-1:0] out_k01,
  output logic signed [KW-1:0] out_k02,
  output logic signed [KW-1:0] out_k12,
  output logic signed [KW-1:0] out_f0,
  output logic signed [KW-1:0] out_f1,
  output logic signed [KW-1:0] out_f2,
  output logic                 out_degenerate
);

  logic en;
  logic load_out;

  // stage 1: input word
  logic                 v1_r;
  logic signed [CW-1:0] x1_r [3];
  logic signed [CW-1:0] y1_r [3];
  logic [2:0]           mask1_r;
  logic [CW-1:0]        g1_r [3];

  // stage 2: edge differences
  logic                 v2_r;
  logic signed [CW-1:0] x2_r [3];
  logic signed [BW-1:0] b2_r [3];
  logic signed [BW-1:0] c2_r [3];
  bc_t                  bc2_r;
  bc_t                  bc2_nxt;

  // stage 3: products
  logic                  v3_r;
  logic signed [PXW-1:0] px3_r [3];
  logic signed [PPW-1:0] bb3_r [NL];
  logic signed [PPW-1:0] cc3_r [NL];
  bc_t                   bc3_r;

  // stage 4: doubled area and numerators
  logic                 v4_r;
  logic signed [SW-1:0] d4_r;
  logic signed [SW-1:0] n4_r [NL];
  bc_t                  bc4_r;

  // stage 5: magnitudes
  logic                 v5_r;
  logic                 degen5_r;
  logic [SW-1:0]        dmag5_r;
  logic [NSW-1:0]       nsh5_r [NL];
  logic [NL-1:0]        neg5_r;
  bc_t                  bc5_r;
  logic [SW-1:0]        dmag5_nxt;
  logic [NSW-1:0]       nsh5_nxt [NL];
  logic [NL-1:0]        neg5_nxt;

  // stage 6: overflow check, divider entry
  logic                 v6_r;
  div_side_t            side6_r;
  logic [SW-1:0]        dmag6_r;
  logic [NL-1:0][NSW-1:0] nsh6_r;
  logic [NL-1:0]        ovf6_nxt;

  // divider output
  logic                 vq;
  div_side_t            sideq;
  logic [NL-1:0][QW-1:0] quo;

  // stage 7: saturated entries
  logic                 v7_r;
  logic [KW-1:0]        k7_r    [NL];
  logic [KW-1:0]        kmag7_r [NL];
  logic [NL-1:0]        kneg7_r;
  logic                 degen7_r;
  bc_t                  bc7_r;
  logic [KW-1:0]        k7_nxt    [NL];
  logic [KW-1:0]        kmag7_nxt [NL];
  logic [NL-1:0]        kneg7_nxt;

  // stage 8: split load products
  logic                 v8_r;
  logic [PW-1:0]        plo8_r [NP];
  logic [PW-1:0]        phi8_r [NP];
  logic [NP-1:0]        sp8_r;
  logic [KW-1:0]        k8_r [NL];
  logic                 degen8_r;
  bc_t                  bc8_r;

  // stage 9: signed load products
  logic                 v9_r;
  logic signed [MW-1:0] m9_r [NP];
  logic [KW-1:0]        k9_r [NL];
  logic                 degen9_r;
  bc_t                  bc9_r;
  logic signed [MW-1:0] m9_nxt [NP];

  // output word
  logic                 out_valid_r;
  logic signed [KW-1:0] k00_r, k11_r, k22_r, k01_r, k02_r, k12_r;
  logic signed [KW-1:0] f0_r, f1_r, f2_r;
  logic                 degen_r;

  // freeze only when the last stage has a word the output cannot take
  assign en       = !(out_valid_r && out_stall && v9_r);
  assign load_out = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= vq;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r[0] <= in_x0;
      x1_r[1] <= in_x1;
      x1_r[2] <= in_x2;
      y1_r[0] <= in_y0;
      y1_r[1] <= in_y1;
      y1_r[2] <= in_y2;
      mask1_r <= in_boundary_mask;
      g1_r[0] <= in_bc_value0;
      g1_r[1] <= in_bc_value1;
      g1_r[2] <= in_bc_value2;
    end
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    bc2_nxt.mask = mask1_r;
    for (int i = 0; i < 3; i++) begin
      bc2_nxt.g[i]    = g1_r[i];
      bc2_nxt.gneg[i] = g1_r[i][CW-1];
      bc2_nxt.gmag[i] = g1_r[i][CW-1] ? (~g1_r[i] + 1'b1) : g1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x2_r[i] <= x1_r[i];
      end
      b2_r[0] <= BW'(y1_r[1]) - BW'(y1_r[2]);
      b2_r[1] <= BW'(y1_r[2]) - BW'(y1_r[0]);
      b2_r[2] <= BW'(y1_r[0]) - BW'(y1_r[1]);
      c2_r[0] <= BW'(x1_r[2]) - BW'(x1_r[1]);
      c2_r[1] <= BW'(x1_r[0]) - BW'(x1_r[2]);
      c2_r[2] <= BW'(x1_r[1]) - BW'(x1_r[0]);
      bc2_r   <= bc2_nxt;
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        px3_r[i] <= x2_r[i] * b2_r[i];
      end
      for (int k = 0; k < NL; k++) begin
        bb3_r[k] <= b2_r[LANE_A[k]] * b2_r[LANE_B[k]];
        cc3_r[k] <= c2_r[LANE_A[k]] * c2_r[LANE_B[k]];
      end
      bc3_r <= bc2_r;
    end
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      d4_r <= SW'(px3_r[0]) + SW'(px3_r[1]) + SW'(px3_r[2]);
      for (int k = 0; k < NL; k++) begin
        n4_r[k] <= SW'(bb3_r[k]) + SW'(cc3_r[k]);
      end
      bc4_r <= bc3_r;
    end
  end

  // ---------------- stage 5 ----------------
  always_comb begin
    dmag5_nxt = d4_r[SW-1] ? (~d4_r + 1'b1) : d4_r;
    for (int k = 0; k < NL; k++) begin
      nsh5_nxt[k] = {(n4_r[k][SW-1] ? (~n4_r[k] + 1'b1) : n4_r[k]), {NUM_SHIFT{1'b0}}};
      neg5_nxt[k] = n4_r[k][SW-1] ^ d4_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen5_r <= (d4_r == '0);
      dmag5_r  <= dmag5_nxt;
      nsh5_r   <= nsh5_nxt;
      neg5_r   <= neg5_nxt;
      bc5_r    <= bc4_r;
    end
  end

  // ---------------- stage 6 ----------------
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      // quotient would need more than QW bits
      ovf6_nxt[k] = SW'(nsh5_r[k][NSW-1:QW]) >= dmag5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r.bc    <= bc5_r;
      side6_r.degen <= degen5_r;
      side6_r.neg   <= neg5_r;
      side6_r.ovf   <= ovf6_nxt;
      dmag6_r       <= dmag5_r;
      for (int k = 0; k < NL; k++) begin
        nsh6_r[k] <= nsh5_r[k];
      end
    end
  end

  p1tem_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_side   (side6_r),
    .in_den    (dmag6_r),
    .in_num    (nsh6_r),
    .out_valid (vq),
    .out_side  (sideq),
    .out_quo   (quo)
  );

  // ---------------- stage 7 ----------------
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      if (sideq.degen) begin
        kmag7_nxt[k] = '0;
      end else if (sideq.ovf[k] ||
                   (sideq.neg[k] ? (quo[k] > Q_NEG_LIM) : (quo[k] > Q_POS_LIM))) begin
        kmag7_nxt[k] = sideq.neg[k] ? K_MIN : K_MAX;
      end else begin
        kmag7_nxt[k] = quo[k][KW-1:0];
      end
      kneg7_nxt[k] = sideq.neg[k] && !sideq.degen;
      k7_nxt[k]    = kneg7_nxt[k] ? (~kmag7_nxt[k] + 1'b1) : kmag7_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k7_r     <= k7_nxt;
      kmag7_r  <= kmag7_nxt;
      kneg7_r  <= kneg7_nxt;
      degen7_r <= sideq.degen;
      bc7_r    <= sideq.bc;
    end
  end

  // ---------------- stage 8 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NP; p++) begin
        plo8_r[p] <= PW'(kmag7_r[PROD_K[p]][KSPLIT-1:0]) * PW'(bc7_r.gmag[PROD_G[p]]);
        phi8_r[p] <= PW'(kmag7_r[PROD_K[p]][KW-1:KSPLIT]) * PW'(bc7_r.gmag[PROD_G[p]]);
        sp8_r[p]  <= kneg7_r[PROD_K[p]] ^ bc7_r.gneg[PROD_G[p]];
      end
      k8_r     <= k7_r;
      degen8_r <= degen7_r;
      bc8_r    <= bc7_r;
    end
  end

  // ---------------- stage 9 ----------------
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      logic [PSW-1:0] full;
      logic [MW-1:0]  mag;
      full      = (PSW'(phi8_r[p]) << KSPLIT) + PSW'(plo8_r[p]);
      mag       = full[PSW-1:FRAC];
      m9_nxt[p] = sp8_r[p] ? (MW'(0) - mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m9_r     <= m9_nxt;
      k9_r     <= k8_r;
      degen9_r <= degen8_r;
      bc9_r    <= bc8_r;
    end
  end

  // ---------------- output word ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && v9_r) begin
      k00_r <= bc9_r.mask[0] ? K_ONE : k9_r[L00];
      k11_r <= bc9_r.mask[1] ? K_ONE : k9_r[L11];
      k22_r <= bc9_r.mask[2] ? K_ONE : k9_r[L22];
      k01_r <= (bc9_r.mask[0] || bc9_r.mask[1]) ? '0 : k9_r[L01];
      k02_r <= (bc9_r.mask[0] || bc9_r.mask[2]) ? '0 : k9_r[L02];
      k12_r <= (bc9_r.mask[1] || bc9_r.mask[2]) ? '0 : k9_r[L12];
      f0_r  <= bc9_r.mask[0] ? KW'($signed(bc9_r.g[0]))
             : load_calc(m9_r[P01], bc9_r.mask[1], m9_r[P02], bc9_r.mask[2]);
      f1_r  <= bc9_r.mask[1] ? KW'($signed(bc9_r.g[1]))
             : load_calc(m9_r[P10], bc9_r.mask[0], m9_r[P12], bc9_r.mask[2]);
      f2_r  <= bc9_r.mask[2] ? KW'($signed(bc9_r.g[2]))
             : load_calc(m9_r[P20], bc9_r.mask[0], m9_r[P21], bc9_r.mask[1]);
      degen_r <= degen9_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_k00        = k00_r;
  assign out_k11        = k11_r;
  assign out_k22        = k22_r;
  assign out_k01        = k01_r;
  assign out_k02        = k02_r;
  assign out_k12        = k12_r;
  assign out_f0         = f0_r;
  assign out_f1         = f1_r;
  assign out_f2         = f2_r;
  assign out_degenerate = degen_r;

  // ---------------- assertions ----------------
  `P1TEM_CHECK(a_stall_needs_full_out, in_stall, out_valid && out_stall && v9_r, "input stalled without a blocked output")
  `P1TEM_CHECK(a_degen_offdiag_zero, out_valid && out_degenerate, out_k01 == '0 && out_k02 == '0 && out_k12 == '0, "degenerate word with non-zero off-diagonal")
  `P1TEM_CHECK(a_rise_from_pipe, $rose(out_valid), $past(v9_r), "output word appeared from an empty pipe")
  `P1TEM_CHECK_NEXT(a_taken_word_refills, out_valid && !out_stall && v9_r, out_valid, "pipe word lost after output taken")

endmodule

`default_nettype wire
